// ===== design/wtpc_pkg.sv =====
`timescale 1ns / 1ps
// wtpc_pkg: widths, fixed-point constants, codes and the pipeline tag type
// for the wind turbine power curve unit; no dependencies

package wtpc_pkg;

   localparam int SPEED_W  = 16;
   localparam int RECIP_W  = 16;
   localparam int CAP_W    = 20;
   localparam int POWER_W  = 28;
   localparam int REGION_W = 2;

   localparam int DEFAULT_EXP_TABLE_ENTRIES = 64;
   localparam int DEFAULT_FRACTION_BITS     = 15;

   // configuration
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESIGN_SPEED_RECIP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY_KW        = 1'd1;
   localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd8192;
   localparam logic [CAP_W-1:0]   CAP_RESET   = 20'd0;

   // curve region codes
   localparam logic [REGION_W-1:0] REGION_NONE  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_BELOW = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE = 2'd2;

   // normalized speed, signed Q.24
   localparam int SPROD_W = SPEED_W + RECIP_W;
   localparam int X_W     = SPROD_W + 1;
   localparam logic signed [X_W-1:0] ONE_Q24   = 33'sd16777216;
   localparam logic signed [X_W-1:0] X_MIN_Q24 = -33'sd12750684;
   localparam logic signed [X_W-1:0] X_MAX_Q24 = 33'sd11408506;

   localparam int MAG_W = 24;
   localparam int SQ_W  = 24;
   localparam int U_W   = 27;
   localparam int A_W   = 28;
   localparam int Q24_SHIFT = 24;
   localparam logic [A_W-1:0] A_BELOW_Q24 = 28'd100258630;
   localparam logic [A_W-1:0] A_ABOVE_Q24 = 28'd156070723;

   // index = u*(N-1)/(9*2^7), division by nine through a reciprocal
   localparam int SPAN_SHIFT = 7;
   localparam int SPAN_DIV   = 9;
   localparam int RECIP9_W     = 30;
   localparam int RECIP9_SHIFT = 33;
   localparam logic [RECIP9_W-1:0] RECIP9 = 30'd954437176;

   localparam int ROM_FRAC_W = 16;
   localparam int EXP_W      = 31;

   // output coefficients, Q.30
   localparam int COEF_W     = 31;
   localparam int COEF_SHIFT = 30;
   localparam int FRAC30_W   = 32;
   localparam logic [COEF_W-1:0] C_BELOW_Q30 = 31'd1108885394;
   localparam logic [COEF_W-1:0] D_BELOW_Q30 = 31'd35143570;
   localparam logic [COEF_W-1:0] C_ABOVE_Q30 = 31'd173452254;
   localparam logic [COEF_W-1:0] D_ABOVE_Q30 = 31'd900289570;

   localparam int POWER_FRAC = 8;

   typedef struct packed {
      logic                valid;
      logic                live;
      logic [REGION_W-1:0] region;
   } wtpc_tag_type;

endpackage

// ===== design/wind_turbine_power_curve_unit.sv =====
`timescale 1ns / 1ps
// wind_turbine_power_curve_unit: top level, configuration registers and
// pipeline flow control; depends on wtpc_pkg, wtpc_norm, wtpc_lookup, wtpc_scale
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/tready      tdata: wind_speed
//   rsp_      out        rsp_tvalid/tready      tdata: power_out, tuser: curve_region
//   csr_      in         csr_valid/ready        csr_index, csr_data
//
// ten register stages, one item per cycle while the output is not stalled
// the depth is set by the chain of multipliers and the registered table read
// all stages advance together whenever the output register is empty or taken
// csr_ready is always high; synchronous reset clears valid bits and tags and loads the configuration registers

module wind_turbine_power_curve_unit
   import wtpc_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = DEFAULT_EXP_TABLE_ENTRIES,
   parameter int FRACTION_BITS     = DEFAULT_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] wind_speed
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [27:0] power_out, [31:28] zero
   output logic [REGION_W-1:0]    rsp_tuser,   // [1:0] curve_region
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [RECIP_W-1:0] recip_ff;
   logic [RECIP_W-1:0] recip_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [CAP_W-1:0]   cap_in;

   always_comb begin
      recip_in = recip_ff;
      cap_in   = cap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DESIGN_SPEED_RECIP: recip_in = csr_data[RECIP_W-1:0];
            CSR_CAPACITY_KW:        cap_in   = csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= RECIP_RESET;
         cap_ff   <= CAP_RESET;
      end else begin
         recip_ff <= recip_in;
         cap_ff   <= cap_in;
      end
   end

   assign csr_ready = 1'b1;

   logic                  advance;
   logic                  out_valid;
   logic [POWER_W-1:0]    power;
   logic [REGION_W-1:0]   region;
   wtpc_tag_type          norm_tag;
   logic [U_W-1:0]        u;
   wtpc_tag_type          look_tag;
   logic [EXP_W-1:0]      entry_a;
   logic [EXP_W-1:0]      entry_b;
   logic [ROM_FRAC_W-1:0] fr;
   logic                  last;

   assign advance = !out_valid || rsp_tready;

   wtpc_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_tvalid),
      .speed    (req_tdata[SPEED_W-1:0]),
      .recip    (recip_ff),
      .tag      (norm_tag),
      .u        (u)
   );

   wtpc_lookup #(
      .ENTRIES (EXP_TABLE_ENTRIES)
   ) u_lookup (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance),
      .in_tag  (norm_tag),
      .u       (u),
      .tag     (look_tag),
      .entry_a (entry_a),
      .entry_b (entry_b),
      .fr      (fr),
      .last    (last)
   );

   wtpc_scale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_tag    (look_tag),
      .entry_a   (entry_a),
      .entry_b   (entry_b),
      .fr        (fr),
      .last      (last),
      .capacity  (cap_ff),
      .out_valid (out_valid),
      .power     (power),
      .region    (region)
   );

   assign req_tready = advance;
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {4'd0, power};
   assign rsp_tuser  = region;

endmodule

// ===== design/wtpc_exp_rom.sv =====
`timescale 1ns / 1ps
// wtpc_exp_rom: exp(-i*4.5/(N-1)) table in Q.30, two registered read ports
// table built at elaboration; depends on wtpc_pkg

module wtpc_exp_rom
   import wtpc_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_EXP_TABLE_ENTRIES
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [$clog2(ENTRIES)-1:0] addr_a,
   input  logic [$clog2(ENTRIES)-1:0] addr_b,
   output logic [EXP_W-1:0]           data_a,
   output logic [EXP_W-1:0]           data_b
);

   localparam int TAYLOR_TERMS = 16;
   localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
   localparam logic [63:0] ONE_Q32    = 64'd4294967296;

   function automatic logic [63:0] div_by_term(input logic [63:0] v, input int n);
      logic [63:0] q;
      begin
         case (n)
            1:       q = v;
            2:       q = v / 2;
            3:       q = v / 3;
            4:       q = v / 4;
            5:       q = v / 5;
            6:       q = v / 6;
            7:       q = v / 7;
            8:       q = v / 8;
            9:       q = v / 9;
            10:      q = v / 10;
            11:      q = v / 11;
            12:      q = v / 12;
            13:      q = v / 13;
            14:      q = v / 14;
            15:      q = v / 15;
            16:      q = v / 16;
            default: q = v;
         endcase
         return q;
      end
   endfunction

   function automatic logic [EXP_W-1:0] rom_entry(input logic [63:0] i);
      logic [63:0]        arg;
      logic [63:0]        whole;
      logic [63:0]        fr;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] acc;
      begin
         arg   = ((i * 64'd9) << 31) / 64'(ENTRIES - 1);
         whole = arg >> 32;
         fr    = arg & 64'hFFFF_FFFF;
         term  = ONE_Q32;
         acc   = $signed(ONE_Q32);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = div_by_term((term * fr) >> 32, n);
            if (n % 2 == 1) begin
               acc = acc - $signed(term);
            end else begin
               acc = acc + $signed(term);
            end
         end
         r = (acc < 0) ? 64'd0 : 64'(acc);
         for (int k = 0; k < 8; k++) begin
            if (64'(k) < whole) begin
               r = (r * EXP_M1_Q32) >> 32;
            end
         end
         return EXP_W'(r >> 2);
      end
   endfunction

   logic [EXP_W-1:0] rom_array [ENTRIES];

   for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
      assign rom_array[g] = rom_entry(64'(g));
   end

   logic [EXP_W-1:0] data_a_ff;
   logic [EXP_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_a_ff <= rom_array[addr_a];
         data_b_ff <= rom_array[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// ===== design/wtpc_norm.sv =====
`timescale 1ns / 1ps
// wtpc_norm: speed normalization, band check, square and curve scaling
// four pipeline stages; depends on wtpc_pkg

module wtpc_norm
   import wtpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [SPEED_W-1:0] speed,
   input  logic [RECIP_W-1:0] recip,
   output wtpc_tag_type       tag,
   output logic [U_W-1:0]     u
);

   localparam int SQP_W = 2 * MAG_W;
   localparam int UP_W  = SQ_W + A_W;

   // stage 1: speed times reciprocal
   logic               valid1_ff;
   logic [SPROD_W-1:0] prod1_ff;
   logic [SPROD_W-1:0] prod1_in;

   assign prod1_in = SPROD_W'(speed) * SPROD_W'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod1_ff <= prod1_in;
      end
   end

   // stage 2: offset, band check, magnitude
   logic signed [X_W-1:0] x;
   logic signed [X_W-1:0] x_neg;
   logic                  inband;
   wtpc_tag_type          tag2_ff;
   wtpc_tag_type          tag2_in;
   logic [MAG_W-1:0]      mag2_ff;
   logic [MAG_W-1:0]      mag2_in;

   always_comb begin
      x       = $signed({1'b0, prod1_ff}) - ONE_Q24;
      x_neg   = -x;
      inband  = (x >= X_MIN_Q24) && (x <= X_MAX_Q24);
      mag2_in = x[X_W-1] ? x_neg[MAG_W-1:0] : x[MAG_W-1:0];
      tag2_in.valid = valid1_ff;
      tag2_in.live  = inband;
      if (!inband) begin
         tag2_in.region = REGION_NONE;
      end else if (x[X_W-1] || (x == '0)) begin
         tag2_in.region = REGION_BELOW;
      end else begin
         tag2_in.region = REGION_ABOVE;
      end
   end

   // stage 3: square
   wtpc_tag_type      tag3_ff;
   logic [SQ_W-1:0]   sq3_ff;
   logic [SQ_W-1:0]   sq3_in;
   logic [SQP_W-1:0]  sq_prod;

   assign sq_prod = SQP_W'(mag2_ff) * SQP_W'(mag2_ff);
   assign sq3_in  = sq_prod[Q24_SHIFT+SQ_W-1:Q24_SHIFT];

   // stage 4: branch coefficient
   wtpc_tag_type     tag4_ff;
   logic [U_W-1:0]   u4_ff;
   logic [U_W-1:0]   u4_in;
   logic [A_W-1:0]   a_coef;
   logic [UP_W-1:0]  u_prod;

   assign a_coef = (tag3_ff.region == REGION_ABOVE) ? A_ABOVE_Q24 : A_BELOW_Q24;
   assign u_prod = UP_W'(sq3_ff) * UP_W'(a_coef);
   assign u4_in  = u_prod[Q24_SHIFT+U_W-1:Q24_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (enable) begin
         tag2_ff <= tag2_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag2_ff <= mag2_in;
         sq3_ff  <= sq3_in;
         u4_ff   <= u4_in;
      end
   end

   assign tag = tag4_ff;
   assign u   = u4_ff;

endmodule

// ===== design/wtpc_lookup.sv =====
`timescale 1ns / 1ps
// wtpc_lookup: table position from the exponent argument, address clamp
// and table read; three stages, the last one holding the table read; depends on
// wtpc_pkg, wtpc_exp_rom

module wtpc_lookup
   import wtpc_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_EXP_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  wtpc_tag_type          in_tag,
   input  logic [U_W-1:0]        u,
   output wtpc_tag_type          tag,
   output logic [EXP_W-1:0]      entry_a,
   output logic [EXP_W-1:0]      entry_b,
   output logic [ROM_FRAC_W-1:0] fr,
   output logic                  last
);

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int PROD_W = U_W + ADDR_W;
   localparam int T_W    = PROD_W - SPAN_SHIFT;
   localparam int Q_W    = T_W - 3;
   localparam int QP_W   = T_W + RECIP9_W;
   localparam int IDX_W  = Q_W - ROM_FRAC_W;

   // stage 5: scale by table span
   wtpc_tag_type      tag5_ff;
   logic [T_W-1:0]    t5_ff;
   logic [T_W-1:0]    t5_in;
   logic [PROD_W-1:0] span_prod;

   assign span_prod = PROD_W'(u) * PROD_W'(ENTRIES - 1);
   assign t5_in     = span_prod[PROD_W-1:SPAN_SHIFT];

   // stage 6: quotient estimate by nine
   wtpc_tag_type    tag6_ff;
   logic [T_W-1:0]  t6_ff;
   logic [Q_W-1:0]  q6_ff;
   logic [Q_W-1:0]  q6_in;
   logic [QP_W-1:0] q_prod;

   assign q_prod = QP_W'(t5_ff) * QP_W'(RECIP9);
   assign q6_in  = q_prod[RECIP9_SHIFT+Q_W-1:RECIP9_SHIFT];

   // stage 7: correction, split, address clamp
   logic [T_W-1:0]        rem;
   logic [Q_W-1:0]        pos;
   logic [IDX_W-1:0]      idx;
   logic [ADDR_W-1:0]     addr_a;
   logic [ADDR_W-1:0]     addr_b;
   logic                  last8_in;
   logic [ROM_FRAC_W-1:0] fr8_in;
   wtpc_tag_type          tag8_ff;
   logic                  last8_ff;
   logic [ROM_FRAC_W-1:0] fr8_ff;

   always_comb begin
      rem      = t6_ff - T_W'(q6_ff) * T_W'(SPAN_DIV);
      pos      = (rem >= T_W'(SPAN_DIV)) ? q6_ff + 1'b1 : q6_ff;
      idx      = pos[Q_W-1:ROM_FRAC_W];
      fr8_in   = pos[ROM_FRAC_W-1:0];
      last8_in = (idx >= IDX_W'(ENTRIES - 1));
      if (last8_in) begin
         addr_a = ADDR_W'(ENTRIES - 1);
         addr_b = ADDR_W'(ENTRIES - 1);
      end else begin
         addr_a = idx[ADDR_W-1:0];
         addr_b = idx[ADDR_W-1:0] + 1'b1;
      end
   end

   wtpc_exp_rom #(
      .ENTRIES (ENTRIES)
   ) u_rom (
      .clock  (clock),
      .enable (enable),
      .addr_a (addr_a),
      .addr_b (addr_b),
      .data_a (entry_a),
      .data_b (entry_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tag5_ff <= '0;
         tag6_ff <= '0;
         tag8_ff <= '0;
      end else if (enable) begin
         tag5_ff <= in_tag;
         tag6_ff <= tag5_ff;
         tag8_ff <= tag6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t5_ff    <= t5_in;
         t6_ff    <= t5_ff;
         q6_ff    <= q6_in;
         last8_ff <= last8_in;
         fr8_ff   <= fr8_in;
      end
   end

   assign tag  = tag8_ff;
   assign fr   = fr8_ff;
   assign last = last8_ff;

endmodule

// ===== design/wtpc_scale.sv =====
`timescale 1ns / 1ps
// wtpc_scale: interpolation, branch coefficients and capacity scaling
// three stages ending in the output register; depends on wtpc_pkg

module wtpc_scale
   import wtpc_pkg::*;
#(
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  wtpc_tag_type          in_tag,
   input  logic [EXP_W-1:0]      entry_a,
   input  logic [EXP_W-1:0]      entry_b,
   input  logic [ROM_FRAC_W-1:0] fr,
   input  logic                  last,
   input  logic [CAP_W-1:0]      capacity,
   output logic                  out_valid,
   output logic [POWER_W-1:0]    power,
   output logic [REGION_W-1:0]   region
);

   localparam int INTERP_W = EXP_W + ROM_FRAC_W;
   localparam int CP_W     = COEF_W + EXP_W;
   localparam int FRAC_W   = FRACTION_BITS + 1;
   localparam int PW_W     = CAP_W + FRAC_W;
   localparam int P_SHIFT  = FRACTION_BITS - POWER_FRAC;

   // stage 9: interpolation
   wtpc_tag_type        tag9_ff;
   logic [EXP_W-1:0]    e9_ff;
   logic [EXP_W-1:0]    e9_in;
   logic [EXP_W-1:0]    diff;
   logic [INTERP_W-1:0] interp_prod;

   always_comb begin
      diff        = entry_a - entry_b;
      interp_prod = INTERP_W'(diff) * INTERP_W'(fr);
      if (last || (entry_a <= entry_b)) begin
         e9_in = entry_a;
      end else begin
         e9_in = entry_a - interp_prod[INTERP_W-1:ROM_FRAC_W];
      end
   end

   // stage 10: power fraction
   wtpc_tag_type        tag10_ff;
   logic [FRAC_W-1:0]   frac10_ff;
   logic [FRAC_W-1:0]   frac10_in;
   logic [COEF_W-1:0]   c_coef;
   logic [CP_W-1:0]     c_prod;
   logic [FRAC30_W-1:0] scaled;
   logic [FRAC30_W-1:0] frac30;

   always_comb begin
      c_coef = (tag9_ff.region == REGION_ABOVE) ? C_ABOVE_Q30 : C_BELOW_Q30;
      c_prod = CP_W'(c_coef) * CP_W'(e9_ff);
      scaled = c_prod[CP_W-1:COEF_SHIFT];
      if (tag9_ff.region == REGION_ABOVE) begin
         frac30 = scaled + FRAC30_W'(D_ABOVE_Q30);
      end else if (scaled > FRAC30_W'(D_BELOW_Q30)) begin
         frac30 = scaled - FRAC30_W'(D_BELOW_Q30);
      end else begin
         frac30 = '0;
      end
      frac10_in = frac30[COEF_SHIFT:COEF_SHIFT-FRACTION_BITS];
   end

   // stage 11: capacity, output register
   logic                valid11_ff;
   logic [POWER_W-1:0]  power11_ff;
   logic [POWER_W-1:0]  power11_in;
   logic [REGION_W-1:0] region11_ff;
   logic [PW_W-1:0]     p_prod;

   always_comb begin
      p_prod = PW_W'(capacity) * PW_W'(frac10_ff);
      if (tag10_ff.live) begin
         power11_in = p_prod[P_SHIFT+POWER_W-1:P_SHIFT];
      end else begin
         power11_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag9_ff    <= '0;
         tag10_ff   <= '0;
         valid11_ff <= 1'b0;
      end else if (enable) begin
         tag9_ff    <= in_tag;
         tag10_ff   <= tag9_ff;
         valid11_ff <= tag10_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e9_ff       <= e9_in;
         frac10_ff   <= frac10_in;
         power11_ff  <= power11_in;
         region11_ff <= tag10_ff.region;
      end
   end

   assign out_valid = valid11_ff;
   assign power     = power11_ff;
   assign region    = region11_ff;

endmodule
